// ===== sv/spr_pkg.sv =====
// spr_pkg: shared types and constants for the spinor potential rotation block
// payload structs, lane control struct, register index codes, default widths
// no dependencies
package spr_pkg;

    localparam int DEF_DATA_BITS = 32;
    localparam int DEF_COEF_BITS = 32;
    localparam int CFG_IDX_W     = 3;

    // q2.30 one in the real half, zero imaginary
    localparam logic [63:0] COEF_ONE = 64'h4000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SU_A,
        REG_SU_B,
        REG_SU_C,
        REG_SU_D,
        REG_PHASE,
        REG_COMP,
        REG_FLAGS
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] c0_re;
        logic signed [31:0] c0_im;
        logic signed [31:0] c1_re;
        logic signed [31:0] c1_im;
        logic signed [31:0] c2_re;
        logic signed [31:0] c2_im;
        logic signed [31:0] c3_re;
        logic signed [31:0] c3_im;
    } spr_in_t;

    typedef struct packed {
        logic signed [31:0] r0_re;
        logic signed [31:0] r0_im;
        logic signed [31:0] r1_re;
        logic signed [31:0] r1_im;
        logic signed [31:0] r2_re;
        logic signed [31:0] r2_im;
        logic signed [31:0] r3_re;
        logic signed [31:0] r3_im;
        logic               saturated;
    } spr_out_t;

    typedef struct packed {
        logic en;
        logic conj;
    } spr_ctl_t;

endpackage

// ===== sv/spr_cmac.sv =====
// spr_cmac: one lane, d0*c0 + d1*c1 complex, optional conjugate of coefficients
// two stages: registered products, then floor shift, sum and saturation
// depends on spr_pkg
module spr_cmac import spr_pkg::*; #(
    parameter int DATA_BITS = DEF_DATA_BITS,
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic                        aclk,
    input  spr_ctl_t                    ctl,
    input  logic signed [DATA_BITS-1:0] d0_re,
    input  logic signed [DATA_BITS-1:0] d0_im,
    input  logic signed [COEF_BITS-1:0] c0_re,
    input  logic signed [COEF_BITS-1:0] c0_im,
    input  logic signed [DATA_BITS-1:0] d1_re,
    input  logic signed [DATA_BITS-1:0] d1_im,
    input  logic signed [COEF_BITS-1:0] c1_re,
    input  logic signed [COEF_BITS-1:0] c1_im,
    output logic signed [DATA_BITS-1:0] q_re,
    output logic signed [DATA_BITS-1:0] q_im,
    output logic                        q_sat
);

    localparam int CW        = COEF_BITS + 1;
    localparam int PW        = DATA_BITS + CW;
    localparam int COEF_FRAC = COEF_BITS - 2;
    localparam int QW        = PW - COEF_FRAC;
    localparam int SW        = QW + 2;
    localparam logic signed [SW-1:0] S_HI = SW'((64'sd1 <<< (DATA_BITS-1)) - 64'sd1);
    localparam logic signed [SW-1:0] S_LO = SW'(-(64'sd1 <<< (DATA_BITS-1)));

    logic signed [CW-1:0] k0r, k0i, k1r, k1i;
    logic signed [PW-1:0] p_next [8];
    logic signed [PW-1:0] p_reg  [8];
    logic signed [QW-1:0] q      [8];
    logic signed [SW-1:0] s_re, s_im;
    logic signed [DATA_BITS-1:0] re_next, im_next, re_reg, im_reg;
    logic sat_next, sat_reg;

    assign k0r = CW'(c0_re);
    assign k1r = CW'(c1_re);
    assign k0i = ctl.conj ? -CW'(c0_im) : CW'(c0_im);
    assign k1i = ctl.conj ? -CW'(c1_im) : CW'(c1_im);

    always_comb begin
        p_next[0] = d0_re * k0r;
        p_next[1] = d0_im * k0i;
        p_next[2] = d0_re * k0i;
        p_next[3] = d0_im * k0r;
        p_next[4] = d1_re * k1r;
        p_next[5] = d1_im * k1i;
        p_next[6] = d1_re * k1i;
        p_next[7] = d1_im * k1r;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            p_reg <= p_next;
        end
    end

    // arithmetic shift gives the floor of each product
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            q[i] = $signed(p_reg[i][PW-1:COEF_FRAC]);
        end
        s_re = SW'(q[0]) - SW'(q[1]) + SW'(q[4]) - SW'(q[5]);
        s_im = SW'(q[2]) + SW'(q[3]) + SW'(q[6]) + SW'(q[7]);
        sat_next = 1'b0;
        if (s_re > S_HI) begin
            re_next  = S_HI[DATA_BITS-1:0];
            sat_next = 1'b1;
        end else if (s_re < S_LO) begin
            re_next  = S_LO[DATA_BITS-1:0];
            sat_next = 1'b1;
        end else begin
            re_next = s_re[DATA_BITS-1:0];
        end
        if (s_im > S_HI) begin
            im_next  = S_HI[DATA_BITS-1:0];
            sat_next = 1'b1;
        end else if (s_im < S_LO) begin
            im_next  = S_LO[DATA_BITS-1:0];
            sat_next = 1'b1;
        end else begin
            im_next = s_im[DATA_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            sat_reg <= sat_next;
        end
    end

    assign q_re  = re_reg;
    assign q_im  = im_reg;
    assign q_sat = sat_reg;

endmodule

// ===== sv/spr_merge.sv =====
// spr_merge: combines lane results into one result item
// back conversion with halving, bypass select, time reversal, 32-bit clip
// depends on spr_pkg
module spr_merge import spr_pkg::*; #(
    parameter int DATA_BITS = DEF_DATA_BITS
) (
    input  logic signed [DATA_BITS-1:0] m_val   [8],
    input  logic signed [DATA_BITS-1:0] byp_val [8],
    input  logic                        rot,
    input  logic                        comp,
    input  logic                        trev,
    input  logic                        sat_in,
    output spr_out_t                    res
);

    localparam int EW = (DATA_BITS > 32) ? DATA_BITS : 32;
    localparam logic signed [EW-1:0] O_HI = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] O_LO = EW'(-64'sd2147483648);
    localparam logic signed [DATA_BITS-1:0] D_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] D_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    logic signed [DATA_BITS:0]   h   [8];
    logic signed [DATA_BITS-1:0] sel [8];
    logic signed [EW-1:0]        w   [8];
    logic        [31:0]          o   [8];
    logic                        flag;

    always_comb begin
        h[0] = (DATA_BITS+1)'(m_val[0]) + (DATA_BITS+1)'(m_val[6]);
        h[1] = (DATA_BITS+1)'(m_val[1]) + (DATA_BITS+1)'(m_val[7]);
        h[2] = (DATA_BITS+1)'(m_val[2]) + (DATA_BITS+1)'(m_val[4]);
        h[3] = (DATA_BITS+1)'(m_val[3]) + (DATA_BITS+1)'(m_val[5]);
        h[4] = (DATA_BITS+1)'(m_val[5]) - (DATA_BITS+1)'(m_val[3]);
        h[5] = (DATA_BITS+1)'(m_val[2]) - (DATA_BITS+1)'(m_val[4]);
        h[6] = (DATA_BITS+1)'(m_val[0]) - (DATA_BITS+1)'(m_val[6]);
        h[7] = (DATA_BITS+1)'(m_val[1]) - (DATA_BITS+1)'(m_val[7]);
        flag = sat_in;
        for (int i = 0; i < 8; i++) begin
            if (!rot) begin
                sel[i] = byp_val[i];
            end else if (comp) begin
                sel[i] = m_val[i];
            end else begin
                sel[i] = $signed(h[i][DATA_BITS:1]);
            end
            if (trev && (i % 2 == 1)) begin
                if (sel[i] == D_MIN) begin
                    sel[i] = D_MAX;
                    flag   = 1'b1;
                end else begin
                    sel[i] = -sel[i];
                end
            end
            w[i] = EW'(sel[i]);
            if (w[i] > O_HI) begin
                w[i] = O_HI;
                flag = 1'b1;
            end else if (w[i] < O_LO) begin
                w[i] = O_LO;
                flag = 1'b1;
            end
            o[i] = w[i][31:0];
        end
        res.r0_re     = o[0];
        res.r0_im     = o[1];
        res.r1_re     = o[2];
        res.r1_im     = o[3];
        res.r2_re     = o[4];
        res.r2_im     = o[5];
        res.r3_re     = o[6];
        res.r3_im     = o[7];
        res.saturated = flag;
    end

endmodule

// ===== sv/spinor_potential_rotation_top.sv =====
// spinor_potential_rotation_top: phase multiply and su(2) rotation of four components
// instantiates spr_cmac lanes and spr_merge; depends on spr_pkg
//
// usage
//   s_ channel: one grid point per transfer, four complex q16.16 components
//   m_ channel: one result per input transfer, rotated components and a clip flag
//   cfg channel: register writes (index, data), always ready, only while idle
// throughput: one transfer per cycle while the skid is free; every lane is fully pipelined
// pipeline: from input transfer to m_valid the chain is the
//   input register, phase lanes (2), composite stage, x/y lanes (2),
//   m lanes (2) and the output register
// stall: a one-entry skid holds the item still leaving the pipe when the
//   receiver stalls; s_ready falls only while the skid is occupied
// reset: aresetn low clears all valid flags and loads the identity matrix,
//   unit phase, separate-field form, rotation and time reversal off
module spinor_potential_rotation_top import spr_pkg::*; #(
    parameter int DATA_BITS = DEF_DATA_BITS,
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  spr_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output spr_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int EW = (DATA_BITS > 32) ? DATA_BITS : 32;
    localparam logic signed [EW-1:0] D_HI = EW'((64'sd1 <<< (DATA_BITS-1)) - 64'sd1);
    localparam logic signed [EW-1:0] D_LO = EW'(-(64'sd1 <<< (DATA_BITS-1)));
    localparam logic signed [DATA_BITS-1:0] D_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] D_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    // configuration registers
    logic [63:0] su_reg [4];
    logic [63:0] phase_reg;
    logic        comp_reg;
    logic [1:0]  flags_reg;
    logic        rot, trev;

    // coefficients: top COEF_BITS of each 32-bit half
    logic signed [COEF_BITS-1:0] cf_re [4];
    logic signed [COEF_BITS-1:0] cf_im [4];
    logic signed [COEF_BITS-1:0] ph_re, ph_im;
    logic signed [COEF_BITS-1:0] c_zero;

    // pipeline control
    logic       en, accept_in;
    logic [7:0] vld_reg;
    logic [7:0] flg_reg;
    spr_ctl_t   ctl_fwd, ctl_cj;

    // input stage
    logic signed [31:0]          in_w   [8];
    logic signed [EW-1:0]        in_e   [8];
    logic signed [DATA_BITS-1:0] x_next [8];
    logic signed [DATA_BITS-1:0] x_reg  [8];
    logic                        in_sat;
    logic signed [DATA_BITS-1:0] d_zero;

    // lanes
    logic signed [DATA_BITS-1:0] v_val  [8];
    logic signed [DATA_BITS-1:0] xy_val [8];
    logic signed [DATA_BITS-1:0] m_val  [8];
    logic [3:0] ph_sat, xy_sat, m_sat;

    // composite stage
    logic signed [DATA_BITS:0]   cs     [8];
    logic signed [DATA_BITS-1:0] d_next [8];
    logic signed [DATA_BITS-1:0] d_reg  [8];
    logic                        c_sat;
    logic signed [DATA_BITS-1:0] byp_reg [4][8];

    // output side
    spr_out_t res;
    spr_out_t out_reg, skid_reg;
    logic     out_valid_reg, skid_full_reg;
    logic     take, incoming;

    function automatic logic signed [DATA_BITS-1:0] sat1(input logic signed [DATA_BITS:0] s);
        if (s[DATA_BITS] != s[DATA_BITS-1]) begin
            return s[DATA_BITS] ? D_MIN : D_MAX;
        end
        return s[DATA_BITS-1:0];
    endfunction

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            su_reg[0] <= COEF_ONE;
            su_reg[1] <= '0;
            su_reg[2] <= '0;
            su_reg[3] <= COEF_ONE;
            phase_reg <= COEF_ONE;
            comp_reg  <= 1'b0;
            flags_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SU_A:  su_reg[0] <= cfg_data;
                REG_SU_B:  su_reg[1] <= cfg_data;
                REG_SU_C:  su_reg[2] <= cfg_data;
                REG_SU_D:  su_reg[3] <= cfg_data;
                REG_PHASE: phase_reg <= cfg_data;
                REG_COMP:  comp_reg  <= cfg_data[0];
                REG_FLAGS: flags_reg <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    assign rot  = flags_reg[0];
    assign trev = flags_reg[1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            cf_re[i] = $signed(su_reg[i][63 -: COEF_BITS]);
            cf_im[i] = $signed(su_reg[i][31 -: COEF_BITS]);
        end
    end

    assign ph_re  = $signed(phase_reg[63 -: COEF_BITS]);
    assign ph_im  = $signed(phase_reg[31 -: COEF_BITS]);
    assign c_zero = '0;
    assign d_zero = '0;

    // whole pipe advances while the skid is free
    assign en        = !skid_full_reg;
    assign s_ready   = en;
    assign accept_in = s_valid && en;

    assign ctl_fwd = '{en: en, conj: 1'b0};
    assign ctl_cj  = '{en: en, conj: 1'b1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], accept_in};
        end
    end

    // input clip to the data range (only bites below 32 bits)
    assign in_w[0] = s_data.c0_re;
    assign in_w[1] = s_data.c0_im;
    assign in_w[2] = s_data.c1_re;
    assign in_w[3] = s_data.c1_im;
    assign in_w[4] = s_data.c2_re;
    assign in_w[5] = s_data.c2_im;
    assign in_w[6] = s_data.c3_re;
    assign in_w[7] = s_data.c3_im;

    always_comb begin
        in_sat = 1'b0;
        for (int i = 0; i < 8; i++) begin
            in_e[i] = EW'(in_w[i]);
            if (in_e[i] > D_HI) begin
                in_e[i] = D_HI;
                in_sat  = 1'b1;
            end else if (in_e[i] < D_LO) begin
                in_e[i] = D_LO;
                in_sat  = 1'b1;
            end
            x_next[i] = in_e[i][DATA_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg      <= x_next;
            flg_reg[0] <= in_sat;
            flg_reg[1] <= flg_reg[0];
            flg_reg[2] <= flg_reg[1];
            flg_reg[3] <= flg_reg[2] | (|ph_sat) | c_sat;
            flg_reg[4] <= flg_reg[3];
            flg_reg[5] <= flg_reg[4];
            flg_reg[6] <= flg_reg[5] | (rot & (|xy_sat));
            flg_reg[7] <= flg_reg[6];
        end
    end

    // phase lanes, one per component
    for (genvar k = 0; k < 4; k++) begin : g_phase
        spr_cmac #(.DATA_BITS(DATA_BITS), .COEF_BITS(COEF_BITS)) u_lane (
            .aclk  (aclk),
            .ctl   (ctl_fwd),
            .d0_re (x_reg[2*k]),
            .d0_im (x_reg[2*k+1]),
            .c0_re (ph_re),
            .c0_im (ph_im),
            .d1_re (d_zero),
            .d1_im (d_zero),
            .c1_re (c_zero),
            .c1_im (c_zero),
            .q_re  (v_val[2*k]),
            .q_im  (v_val[2*k+1]),
            .q_sat (ph_sat[k])
        );
    end

    // separate fields to composite 2x2 form when rotation is on and composite is off
    always_comb begin
        cs[0] = (DATA_BITS+1)'(v_val[0]) + (DATA_BITS+1)'(v_val[6]);
        cs[1] = (DATA_BITS+1)'(v_val[1]) + (DATA_BITS+1)'(v_val[7]);
        cs[2] = (DATA_BITS+1)'(v_val[2]) + (DATA_BITS+1)'(v_val[5]);
        cs[3] = (DATA_BITS+1)'(v_val[3]) - (DATA_BITS+1)'(v_val[4]);
        cs[4] = (DATA_BITS+1)'(v_val[2]) - (DATA_BITS+1)'(v_val[5]);
        cs[5] = (DATA_BITS+1)'(v_val[3]) + (DATA_BITS+1)'(v_val[4]);
        cs[6] = (DATA_BITS+1)'(v_val[0]) - (DATA_BITS+1)'(v_val[6]);
        cs[7] = (DATA_BITS+1)'(v_val[1]) - (DATA_BITS+1)'(v_val[7]);
        c_sat = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (rot && !comp_reg) begin
                d_next[i] = sat1(cs[i]);
                c_sat     = c_sat | (cs[i][DATA_BITS] ^ cs[i][DATA_BITS-1]);
            end else begin
                d_next[i] = v_val[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg      <= d_next;
            byp_reg[0] <= d_reg;
            byp_reg[1] <= byp_reg[0];
            byp_reg[2] <= byp_reg[1];
            byp_reg[3] <= byp_reg[2];
        end
    end

    // x0, x1, y0, y1 lanes against conjugated a, b / c, d
    for (genvar j = 0; j < 4; j++) begin : g_xy
        spr_cmac #(.DATA_BITS(DATA_BITS), .COEF_BITS(COEF_BITS)) u_lane (
            .aclk  (aclk),
            .ctl   (ctl_cj),
            .d0_re (d_reg[4*(j%2)]),
            .d0_im (d_reg[4*(j%2)+1]),
            .c0_re (cf_re[(j/2)*2]),
            .c0_im (cf_im[(j/2)*2]),
            .d1_re (d_reg[4*(j%2)+2]),
            .d1_im (d_reg[4*(j%2)+3]),
            .c1_re (cf_re[(j/2)*2+1]),
            .c1_im (cf_im[(j/2)*2+1]),
            .q_re  (xy_val[2*j]),
            .q_im  (xy_val[2*j+1]),
            .q_sat (xy_sat[j])
        );
    end

    // m0..m3 lanes: a, b or c, d times x or y pairs
    for (genvar m = 0; m < 4; m++) begin : g_m
        spr_cmac #(.DATA_BITS(DATA_BITS), .COEF_BITS(COEF_BITS)) u_lane (
            .aclk  (aclk),
            .ctl   (ctl_fwd),
            .d0_re (xy_val[4*(m%2)]),
            .d0_im (xy_val[4*(m%2)+1]),
            .c0_re (cf_re[(m/2)*2]),
            .c0_im (cf_im[(m/2)*2]),
            .d1_re (xy_val[4*(m%2)+2]),
            .d1_im (xy_val[4*(m%2)+3]),
            .c1_re (cf_re[(m/2)*2+1]),
            .c1_im (cf_im[(m/2)*2+1]),
            .q_re  (m_val[2*m]),
            .q_im  (m_val[2*m+1]),
            .q_sat (m_sat[m])
        );
    end

    spr_merge #(.DATA_BITS(DATA_BITS)) u_merge (
        .m_val   (m_val),
        .byp_val (byp_reg[3]),
        .rot     (rot),
        .comp    (comp_reg),
        .trev    (trev),
        .sat_in  (flg_reg[7] | (rot & (|m_sat))),
        .res     (res)
    );

    // output register with one skid entry
    assign take     = out_valid_reg && m_ready;
    assign incoming = en && vld_reg[7];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (take) begin
                skid_full_reg <= 1'b0;
            end
        end else if (incoming) begin
            if (out_valid_reg && !take) begin
                skid_full_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (incoming) begin
            if (out_valid_reg && !take) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sv/spr_checker.sv =====
// spr_checker: port-level checks on the spinor potential rotation block
// bound to spinor_potential_rotation_top; depends on spr_pkg
module spr_checker import spr_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input spr_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not empty after reset");

    // input back-pressure only follows a stalled output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input stalled without output stall");

    // while input is held off the output is still waiting
    a_ready_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

endmodule

bind spinor_potential_rotation_top spr_checker u_spr_checker (.*);

// ===== tb/tb.sv =====
// tb: self-checking testbench for spinor_potential_rotation_top
// drives grid points and register writes, predicts each rotated result, checks it
// depends on spr_pkg and the block under test
module tb import spr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DATA_HI   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DATA_LO   = -DATA_HI - 1;
    localparam longint PROD_CAP  = 64'sh1000_0000_0000_0000;
    localparam int     COEF_FRAC = DEF_COEF_BITS - 2;
    localparam int     LATENCY   = 9;
    localparam int     CYCLE_CAP = 400000;
    localparam int     NUM_PHASES = 9;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = CFG_IDX_W'(REG_FLAGS) + 1'b1;

    typedef struct {
        longint re;
        longint im;
    } cplx_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    spr_in_t              s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    spr_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    // register mirror used by the predictor
    logic [63:0] mir_a = COEF_ONE, mir_b = '0, mir_c = '0, mir_d = COEF_ONE;
    logic [63:0] mir_phase = COEF_ONE;
    logic        mir_comp = 1'b0;
    logic [1:0]  mir_flags = 2'b00;

    spr_in_t  pending_points[$];
    spr_out_t rotated_expect[$];
    int       src_idle_pct = 0;
    int       sink_idle_pct = 0;
    int       n_fail = 0;
    int       n_points = 0;
    int       n_checked = 0;
    int       n_clipped = 0;
    int       cycles = 0;
    bit       clip_seen;

    spinor_potential_rotation_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------
    // fixed-point predictor
    // ---------------------------------------------------------------

    // clip to the signed 32-bit range and note that clipping happened
    function automatic longint clip32(longint v);
        if (v > DATA_HI) begin
            clip_seen = 1'b1;
            return DATA_HI;
        end
        if (v < DATA_LO) begin
            clip_seen = 1'b1;
            return DATA_LO;
        end
        return v;
    endfunction

    // data times q2.30 coefficient, floored, with the product magnitude cap
    function automatic longint qmul(longint x, longint c);
        longint q;
        q = (x * c) >>> COEF_FRAC;
        if (q > PROD_CAP) begin
            clip_seen = 1'b1;
            q = PROD_CAP;
        end else if (q < -PROD_CAP) begin
            clip_seen = 1'b1;
            q = -PROD_CAP;
        end
        return q;
    endfunction

    function automatic cplx_t cmul(cplx_t x, cplx_t y, bit cj);
        cplx_t  r;
        longint yi;
        yi = cj ? -y.im : y.im;
        r.re = qmul(x.re, y.re) - qmul(x.im, yi);
        r.im = qmul(x.re, yi) + qmul(x.im, y.re);
        return r;
    endfunction

    function automatic cplx_t csat(longint re, longint im);
        cplx_t r;
        r.re = clip32(re);
        r.im = clip32(im);
        return r;
    endfunction

    function automatic cplx_t mac_pair(cplx_t x0, cplx_t y0, cplx_t x1, cplx_t y1, bit cj);
        cplx_t p, q;
        p = cmul(x0, y0, cj);
        q = cmul(x1, y1, cj);
        return csat(p.re + q.re, p.im + q.im);
    endfunction

    function automatic cplx_t coef_of(logic [63:0] w);
        cplx_t r;
        r.re = longint'($signed(w[63:32]));
        r.im = longint'($signed(w[31:0]));
        return r;
    endfunction

    function automatic spr_out_t rotate_point(spr_in_t p);
        logic signed [31:0] f[8];
        cplx_t    v[4];
        cplx_t    ph, ua, ub, uc, ud, d0, d1, d2, d3, x0, x1, y0, y1, m0, m1, m2, m3;
        spr_out_t r;
        f = '{p.c0_re, p.c0_im, p.c1_re, p.c1_im, p.c2_re, p.c2_im, p.c3_re, p.c3_im};
        clip_seen = 1'b0;
        ph = coef_of(mir_phase);
        for (int k = 0; k < 4; k++) begin
            cplx_t x, t;
            x.re = longint'(f[2*k]);
            x.im = longint'(f[2*k+1]);
            t = cmul(x, ph, 1'b0);
            v[k] = csat(t.re, t.im);
        end
        if (mir_flags[0]) begin
            ua = coef_of(mir_a);
            ub = coef_of(mir_b);
            uc = coef_of(mir_c);
            ud = coef_of(mir_d);
            d0 = v[0]; d1 = v[1]; d2 = v[2]; d3 = v[3];
            // separate fields to pauli composite form
            if (!mir_comp) begin
                d0 = csat(v[0].re + v[3].re, v[0].im + v[3].im);
                d1 = csat(v[1].re + v[2].im, v[1].im - v[2].re);
                d2 = csat(v[1].re - v[2].im, v[1].im + v[2].re);
                d3 = csat(v[0].re - v[3].re, v[0].im - v[3].im);
            end
            x0 = mac_pair(d0, ua, d1, ub, 1'b1);
            x1 = mac_pair(d2, ua, d3, ub, 1'b1);
            y0 = mac_pair(d0, uc, d1, ud, 1'b1);
            y1 = mac_pair(d2, uc, d3, ud, 1'b1);
            m0 = mac_pair(ua, x0, ub, x1, 1'b0);
            m1 = mac_pair(ua, y0, ub, y1, 1'b0);
            m2 = mac_pair(uc, x0, ud, x1, 1'b0);
            m3 = mac_pair(uc, y0, ud, y1, 1'b0);
            if (mir_comp) begin
                v[0] = m0; v[1] = m1; v[2] = m2; v[3] = m3;
            end else begin
                v[0].re = (m0.re + m3.re) >>> 1; v[0].im = (m0.im + m3.im) >>> 1;
                v[1].re = (m1.re + m2.re) >>> 1; v[1].im = (m1.im + m2.im) >>> 1;
                v[2].re = (m2.im - m1.im) >>> 1; v[2].im = (m1.re - m2.re) >>> 1;
                v[3].re = (m0.re - m3.re) >>> 1; v[3].im = (m0.im - m3.im) >>> 1;
            end
        end
        if (mir_flags[1]) begin
            for (int k = 0; k < 4; k++) v[k].im = clip32(-v[k].im);
        end
        r.r0_re = v[0].re[31:0]; r.r0_im = v[0].im[31:0];
        r.r1_re = v[1].re[31:0]; r.r1_im = v[1].im[31:0];
        r.r2_re = v[2].re[31:0]; r.r2_im = v[2].im[31:0];
        r.r3_re = v[3].re[31:0]; r.r3_im = v[3].im[31:0];
        r.saturated = clip_seen;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly full range, some small q16.16 values, some extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0, 1: return $urandom;
            2:    return 32'($signed($urandom_range(2 * 262144)) - 262144);
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic spr_in_t pick_point();
        spr_in_t p;
        p = {pick_word(), pick_word(), pick_word(), pick_word(),
             pick_word(), pick_word(), pick_word(), pick_word()};
        return p;
    endfunction

    // coefficient half: within +-1.0 mostly, sometimes anything, sometimes an end
    function automatic logic [31:0] pick_coef_half();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(2 * 32'h4000_0000)) - 32'sh4000_0000);
        endcase
    endfunction

    function automatic logic [63:0] pick_coef();
        return {pick_coef_half(), pick_coef_half()};
    endfunction

    // one register write, only while idle; the mirror follows on the transfer
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        case (cfg_reg_t'(idx))
            REG_SU_A:  mir_a = val;
            REG_SU_B:  mir_b = val;
            REG_SU_C:  mir_c = val;
            REG_SU_D:  mir_d = val;
            REG_PHASE: mir_phase = val;
            REG_COMP:  mir_comp = val[0];
            REG_FLAGS: mir_flags = val[1:0];
            default:   ;
        endcase
    endtask

    // hold until everything queued has come back, then let the pipe drain
    task automatic wait_drained();
        wait (pending_points.size() == 0 && rotated_expect.size() == 0 && !s_valid);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // extremes of every field plus the corner of conjugating the most negative value
    task automatic queue_corners();
        pending_points.push_back('0);
        pending_points.push_back({8{32'h7FFF_FFFF}});
        pending_points.push_back({8{32'h8000_0000}});
        pending_points.push_back({8{32'hFFFF_FFFF}});
        pending_points.push_back({4{32'h7FFF_FFFF, 32'h8000_0000}});
        pending_points.push_back({4{32'h0001_0000, 32'h8000_0000}});
    endtask

    // ---------------------------------------------------------------
    // reset, driver, monitor, run limit
    // ---------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver: presents queued points, predicts on each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rotated_expect.push_back(rotate_point(s_data));
                n_points++;
            end
            if (!s_valid || s_ready) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_points.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, compares each transfer with the oldest prediction
    always @(posedge aclk) begin
        spr_out_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
            if (m_valid && m_ready) begin
                if (rotated_expect.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_data);
                    n_fail++;
                end else begin
                    exp_r = rotated_expect.pop_front();
                    n_checked++;
                    if (exp_r.saturated) n_clipped++;
                    if (m_data.r0_re !== exp_r.r0_re) begin
                        $error("r0_re expected %0d got %0d", exp_r.r0_re, m_data.r0_re);
                        n_fail++;
                    end
                    if (m_data.r0_im !== exp_r.r0_im) begin
                        $error("r0_im expected %0d got %0d", exp_r.r0_im, m_data.r0_im);
                        n_fail++;
                    end
                    if (m_data.r1_re !== exp_r.r1_re) begin
                        $error("r1_re expected %0d got %0d", exp_r.r1_re, m_data.r1_re);
                        n_fail++;
                    end
                    if (m_data.r1_im !== exp_r.r1_im) begin
                        $error("r1_im expected %0d got %0d", exp_r.r1_im, m_data.r1_im);
                        n_fail++;
                    end
                    if (m_data.r2_re !== exp_r.r2_re) begin
                        $error("r2_re expected %0d got %0d", exp_r.r2_re, m_data.r2_re);
                        n_fail++;
                    end
                    if (m_data.r2_im !== exp_r.r2_im) begin
                        $error("r2_im expected %0d got %0d", exp_r.r2_im, m_data.r2_im);
                        n_fail++;
                    end
                    if (m_data.r3_re !== exp_r.r3_re) begin
                        $error("r3_re expected %0d got %0d", exp_r.r3_re, m_data.r3_re);
                        n_fail++;
                    end
                    if (m_data.r3_im !== exp_r.r3_im) begin
                        $error("r3_im expected %0d got %0d", exp_r.r3_im, m_data.r3_im);
                        n_fail++;
                    end
                    if (m_data.saturated !== exp_r.saturated) begin
                        $error("saturated expected %0b got %0b",
                               exp_r.saturated, m_data.saturated);
                        n_fail++;
                    end
                end
            end
        end
    end

    // run limit, far above the slowest legal run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [63:0] u_word;
        wait (aresetn);
        src_idle_pct  = 9;
        sink_idle_pct = 85;

        // directed part at reset settings: phase only
        queue_corners();
        for (int i = 0; i < 10; i++) pending_points.push_back(pick_point());
        wait_drained();

        // every mode, including rotation off with composite set, and both coefficient ends
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES / 3) begin
                src_idle_pct  = 85;
                sink_idle_pct = 9;
            end else if (ph == 2 * NUM_PHASES / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (ph)
                0: begin
                    // identity rotation, separate fields
                    write_reg(REG_FLAGS, 64'(2'b01));
                end
                1: begin
                    // rotation off ignores the composite form
                    write_reg(REG_COMP, 64'd1);
                    write_reg(REG_FLAGS, 64'(2'b10));
                    write_reg(REG_PHASE, pick_coef());
                end
                2: begin
                    // most negative coefficient everywhere, conjugate on
                    u_word = {32'h8000_0000, 32'h8000_0000};
                    write_reg(REG_SU_A, u_word);
                    write_reg(REG_SU_B, u_word);
                    write_reg(REG_SU_C, u_word);
                    write_reg(REG_SU_D, u_word);
                    write_reg(REG_PHASE, u_word);
                    write_reg(REG_FLAGS, 64'(2'b11));
                end
                3: begin
                    // largest coefficient everywhere, separate fields
                    u_word = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
                    write_reg(REG_SU_A, u_word);
                    write_reg(REG_SU_B, u_word);
                    write_reg(REG_SU_C, u_word);
                    write_reg(REG_SU_D, u_word);
                    write_reg(REG_PHASE, u_word);
                    write_reg(REG_COMP, 64'd0);
                    write_reg(REG_FLAGS, 64'(2'b01));
                end
                default: begin
                    write_reg(REG_SU_A, pick_coef());
                    write_reg(REG_SU_B, pick_coef());
                    write_reg(REG_SU_C, pick_coef());
                    write_reg(REG_SU_D, pick_coef());
                    write_reg(REG_PHASE, pick_coef());
                    // upper data bits must not matter
                    write_reg(REG_COMP, {$urandom, $urandom});
                    write_reg(REG_FLAGS, {$urandom, $urandom});
                    // write past the register list, must be ignored
                    write_reg(IDX_UNUSED, {$urandom, $urandom});
                end
            endcase
            queue_corners();
            for (int i = 0; i < 180; i++) pending_points.push_back(pick_point());
            // sender holds until every outstanding result is back
            wait_drained();
        end

        if (rotated_expect.size() != 0) begin
            $error("%0d expected results never arrived", rotated_expect.size());
            n_fail++;
        end
        $display("covered %0d grid points over %0d register settings, %0d with clipping",
                 n_points, NUM_PHASES + 1, n_clipped);
        $display("%0d results compared, %0d mismatches", n_checked, n_fail);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/spr_pkg.sv
sv/spr_cmac.sv
sv/spr_merge.sv
sv/spinor_potential_rotation_top.sv
sv/spr_checker.sv
tb/tb.sv
